// ===== hdl/gas_sensor_qualifier_averager_defines.svh =====
// Assertion helpers shared by the qualifier/averager modules.
// Every check is clocked on clk and masked while rst_n is low.
`ifndef GAS_SENSOR_QUALIFIER_AVERAGER_DEFINES_SVH
`define GAS_SENSOR_QUALIFIER_AVERAGER_DEFINES_SVH

// Plain property check.
`define GSQA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define GSQA_ASSERT_IMP(label, ante, cons, msg) \
    `GSQA_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== hdl/gsqa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gsqa_pkg;

    // Ring length default
    localparam int WINDOW_SIZE_DEF = 10;

    // Register file
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [15:0] MIN_PPM_RST     = 16'd300;
    localparam logic [15:0] MAX_PPM_RST     = 16'd5000;
    localparam logic [3:0]  FAIL_LIMIT_RST  = 4'd5;
    localparam logic [31:0] RECOVERY_RST    = 32'd600000;
    localparam logic [31:0] WARMUP_RST      = 32'd180000;

    // Failure counter saturation point
    localparam logic [3:0]  FAIL_SAT        = 4'd15;

    // Request queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        REG_MIN_PPM    = 3'd0,
        REG_MAX_PPM    = 3'd1,
        REG_FAIL_LIMIT = 3'd2,
        REG_RECOVERY   = 3'd3,
        REG_WARMUP     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] min_valid_ppm;
        logic [15:0] max_valid_ppm;
        logic [3:0]  fail_limit;
        logic [31:0] recovery_interval_ms;
        logic [31:0] warmup_ms;
    } cfg_t;

    typedef struct packed {
        logic               action;
        logic [31:0]        now_ms;
        logic [15:0]        gas_reading;
        logic signed [7:0]  sensor_temperature;
    } item_t;

    typedef struct packed {
        logic [15:0]        average_ppm;
        logic signed [7:0]  temperature_out;
        logic               sensor_enabled;
        logic               warmed_up;
        logic [3:0]         failure_count;
        logic               reading_used;
    } result_t;

    // Classified request as held in the queue
    typedef struct packed {
        logic               is_reset;
        logic [31:0]        now_ms;
        logic [15:0]        gas_reading;
        logic signed [7:0]  temperature;
        logic               in_window;
        logic               past_warmup;
    } cls_t;

endpackage

`default_nettype wire

// ===== hdl/gsqa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsqa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/gsqa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "gas_sensor_qualifier_averager_defines.svh"

module gsqa_front
    import gsqa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    input  wire logic  pop,
    output logic       head_valid,
    output cls_t       head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cls_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    cls_t             entry;

    // classify against the window and warm-up time while config is stable
    always_comb
    begin
        entry.is_reset    = item.action;
        entry.now_ms      = item.now_ms;
        entry.gas_reading = item.gas_reading;
        entry.temperature = item.sensor_temperature;
        entry.in_window   = (item.gas_reading >= cfg.min_valid_ppm) &&
                            (item.gas_reading <= cfg.max_valid_ppm);
        entry.past_warmup = item.now_ms > cfg.warmup_ms;
    end

    assign item_stall = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

    // back end only takes a request that is there
    `GSQA_ASSERT_IMP(a_pop_needs_entry, pop, cnt_reg != '0, "pop from empty request queue")

endmodule

`default_nettype wire

// ===== hdl/gsqa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "gas_sensor_qualifier_averager_defines.svh"

module gsqa_back
    import gsqa_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic head_valid,
    input  wire cls_t head,
    output logic      pop,
    output logic      result_valid,
    input  wire logic result_stall,
    output result_t   result
);

    localparam int IDX_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W  = 16 + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   ring_idx_reg, ring_idx_next;
    logic               ring_full_reg, ring_full_next;
    logic               enabled_reg, enabled_next;
    logic               warm_reg, warm_next;
    logic [3:0]         fail_cnt_reg, fail_cnt_next;
    logic [31:0]        last_tick_reg, last_tick_next;
    logic [15:0]        avg_reg, avg_next;
    logic signed [7:0]  temp_reg, temp_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               result_valid_reg, result_valid_next;

    logic               used_reg, used_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    result_t            result_reg, result_next;

    logic               ram_we;
    logic [15:0]        ram_rdata;
    logic [31:0]        elapsed;
    logic               tick;
    logic [3:0]         fail_inc;
    logic               idx_wrap;
    logic               issue;
    logic [CNT_W:0]     shifted;
    logic [CNT_W:0]     diff;
    logic               ge;

    gsqa_ram #(
        .WIDTH (16),
        .DEPTH (WINDOW_SIZE)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_idx_reg),
        .wdata (head.gas_reading),
        .raddr (rd_addr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign elapsed  = head.now_ms - last_tick_reg;
    assign tick     = elapsed >= cfg.recovery_interval_ms;
    assign fail_inc = (fail_cnt_reg != FAIL_SAT) ? fail_cnt_reg + 4'd1 : fail_cnt_reg;
    assign idx_wrap = (ring_idx_reg == IDX_W'(WINDOW_SIZE - 1));
    assign issue    = (rd_addr_reg != count_reg);

    // one restoring division step per cycle
    assign shifted  = {rem_reg, quo_reg[SUM_W-1]};
    assign diff     = shifted - {1'b0, count_reg};
    assign ge       = (shifted >= {1'b0, count_reg});

    always_comb
    begin
        state_next        = state_reg;
        ring_idx_next     = ring_idx_reg;
        ring_full_next    = ring_full_reg;
        enabled_next      = enabled_reg;
        warm_next         = warm_reg;
        fail_cnt_next     = fail_cnt_reg;
        last_tick_next    = last_tick_reg;
        avg_next          = avg_reg;
        temp_next         = temp_reg;
        rd_pend_next      = 1'b0;
        result_valid_next = result_valid_reg && result_stall;
        used_next         = used_reg;
        count_next        = count_reg;
        rd_addr_next      = rd_addr_reg;
        acc_next          = acc_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        step_next         = step_reg;
        result_next       = result_reg;
        ram_we            = 1'b0;
        pop               = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    state_next = ST_OUT;
                    used_next  = 1'b0;
                    if (head.is_reset)
                    begin
                        fail_cnt_next  = '0;
                        enabled_next   = 1'b1;
                        ring_full_next = 1'b0;
                        ring_idx_next  = '0;
                    end
                    else
                    begin
                        if (tick)
                        begin
                            last_tick_next = head.now_ms;
                        end
                        if (enabled_reg || tick)
                        begin
                            used_next = 1'b1;
                            if (!head.in_window)
                            begin
                                // failure only counts while enabled
                                if (enabled_reg)
                                begin
                                    fail_cnt_next = fail_inc;
                                    if (fail_inc >= cfg.fail_limit)
                                    begin
                                        enabled_next = 1'b0;
                                    end
                                end
                            end
                            else
                            begin
                                enabled_next  = 1'b1;
                                fail_cnt_next = '0;
                                warm_next     = warm_reg || head.past_warmup;
                                temp_next     = head.temperature;
                                ram_we        = 1'b1;
                                ring_idx_next = idx_wrap ? '0 : ring_idx_reg + IDX_W'(1);
                                ring_full_next = ring_full_reg || idx_wrap;
                                count_next    = (ring_full_reg || idx_wrap) ?
                                                CNT_W'(WINDOW_SIZE) :
                                                CNT_W'(ring_idx_reg) + CNT_W'(1);
                                rd_addr_next  = '0;
                                acc_next      = '0;
                                state_next    = ST_SUM;
                            end
                        end
                    end
                end
            end

            ST_SUM:
            begin
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + CNT_W'(1);
                end
                rd_pend_next = issue;
                if (rd_pend_reg)
                begin
                    acc_next = acc_reg + SUM_W'(ram_rdata);
                end
                if (!issue && !rd_pend_reg)
                begin
                    rem_next   = '0;
                    quo_next   = acc_reg;
                    step_next  = STEP_W'(SUM_W - 1);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], ge};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    avg_next   = quo_next[15:0];
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.average_ppm     = avg_reg;
                    result_next.temperature_out = temp_reg;
                    result_next.sensor_enabled  = enabled_reg;
                    result_next.warmed_up       = warm_reg;
                    result_next.failure_count   = fail_cnt_reg;
                    result_next.reading_used    = used_reg;
                    result_valid_next           = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ring_idx_reg     <= '0;
            ring_full_reg    <= 1'b0;
            enabled_reg      <= 1'b1;
            warm_reg         <= 1'b0;
            fail_cnt_reg     <= '0;
            last_tick_reg    <= '0;
            avg_reg          <= '0;
            temp_reg         <= '0;
            rd_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ring_idx_reg     <= ring_idx_next;
            ring_full_reg    <= ring_full_next;
            enabled_reg      <= enabled_next;
            warm_reg         <= warm_next;
            fail_cnt_reg     <= fail_cnt_next;
            last_tick_reg    <= last_tick_next;
            avg_reg          <= avg_next;
            temp_reg         <= temp_next;
            rd_pend_reg      <= rd_pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        used_reg    <= used_next;
        count_reg   <= count_next;
        rd_addr_reg <= rd_addr_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // divisor is the filled count, never zero nor beyond the ring
    `GSQA_ASSERT_IMP(a_div_count, state_reg == ST_DIV, (count_reg != '0) && (count_reg <= CNT_W'(WINDOW_SIZE)), "bad divisor")
    // ring reads drained before the next request
    `GSQA_ASSERT_IMP(a_idle_drained, state_reg == ST_IDLE, !rd_pend_reg, "ring read pending in idle")
    // the sensor is only ever disabled by a counted failure
    `GSQA_ASSERT_IMP(a_disable_counted, !enabled_reg, fail_cnt_reg != '0, "disabled with no failures")

endmodule

`default_nettype wire

// ===== hdl/gas_sensor_qualifier_averager.sv =====
// Flow: a request without a good reading (reset requests too) passes the back end's idle and
// output states into the result register; a good reading also passes the sum state (count
// ring reads through the registered RAM read, count = filled ring entries) and a 20-step
// one-bit-per-cycle divider. The back end is busy until its result is registered; 2-entry queue.
// Reset (rst_n, async, active low) restores the register defaults, enables the sensor and
// empties the ring; the ring RAM itself is not cleared, only its fill count.
`timescale 1ns / 1ps
`default_nettype none

module gas_sensor_qualifier_averager
    import gsqa_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    // request channel
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire item_t             item,

    // result channel
    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_t                result,

    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    // Register map, one 32-bit word each:
    //   0x00 min_valid_ppm, 0x04 max_valid_ppm, 0x08 fail_limit,
    //   0x0C recovery_interval_ms, 0x10 warmup_ms.
    // Writes outside the map are dropped and read back as zero.

    cfg_t     cfg_reg;
    reg_idx_t reg_sel;
    logic     cfg_wr;
    logic     head_valid;
    cls_t     head;
    logic     pop;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_valid_ppm        <= MIN_PPM_RST;
            cfg_reg.max_valid_ppm        <= MAX_PPM_RST;
            cfg_reg.fail_limit           <= FAIL_LIMIT_RST;
            cfg_reg.recovery_interval_ms <= RECOVERY_RST;
            cfg_reg.warmup_ms            <= WARMUP_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_MIN_PPM:    cfg_reg.min_valid_ppm        <= pwdata[15:0];
                REG_MAX_PPM:    cfg_reg.max_valid_ppm        <= pwdata[15:0];
                REG_FAIL_LIMIT: cfg_reg.fail_limit           <= pwdata[3:0];
                REG_RECOVERY:   cfg_reg.recovery_interval_ms <= pwdata;
                REG_WARMUP:     cfg_reg.warmup_ms            <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MIN_PPM:    prdata = {16'd0, cfg_reg.min_valid_ppm};
            REG_MAX_PPM:    prdata = {16'd0, cfg_reg.max_valid_ppm};
            REG_FAIL_LIMIT: prdata = {28'd0, cfg_reg.fail_limit};
            REG_RECOVERY:   prdata = cfg_reg.recovery_interval_ms;
            REG_WARMUP:     prdata = cfg_reg.warmup_ms;
            default:        prdata = '0;
        endcase
    end

    // front: takes requests, checks the reading window and warm-up time, queues them
    gsqa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: sensor state, ring, averaging and the result register
    gsqa_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the gas sensor qualifier / averager.
// A clocked driver feeds requests from a queue that the main initial block fills;
// a clocked monitor checks every result against a predictor that runs on each
// accepted request.
module tb_top;
    import gsqa_pkg::*;

    localparam int          RING_LEN      = WINDOW_SIZE_DEF;
    localparam logic        ACT_UPDATE    = 1'b0;
    localparam logic        ACT_RESET     = 1'b1;
    localparam int          PHASE_ITEMS   = 265;
    localparam int          SETTLE_CYCLES = 40;     // covers a good reading's ring reads and divide
    localparam int          HOLD_AT       = 400;    // results seen before the long hold-off
    localparam int          HOLD_CYCLES   = 300;
    localparam int          TIMEOUT_NS    = 8_000_000;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  req_bus      = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                res_bus;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [ADDR_W-1:0]      paddr        = '0;
    logic [DATA_W-1:0]      pwdata       = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    gas_sensor_qualifier_averager u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (req_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (res_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the register file, updated only after a write has landed
    // ------------------------------------------------------------------
    logic [15:0]            cfg_min      = MIN_PPM_RST;
    logic [15:0]            cfg_max      = MAX_PPM_RST;
    logic [3:0]             cfg_limit    = FAIL_LIMIT_RST;
    logic [31:0]            cfg_recovery = RECOVERY_RST;
    logic [31:0]            cfg_warmup   = WARMUP_RST;

    // ------------------------------------------------------------------
    // Predicted sensor state (post-reset values)
    // ------------------------------------------------------------------
    logic [15:0]            hist_ppm [RING_LEN];
    int                     hist_pos     = 0;
    logic                   hist_full    = 1'b0;
    logic                   sens_on      = 1'b1;
    logic                   warm_done    = 1'b0;
    logic [3:0]             fail_run     = '0;
    logic [31:0]            last_tick    = '0;
    logic [15:0]            avg_ppm      = '0;
    logic signed [7:0]      good_temp    = '0;

    item_t                  pending_requests [$];
    result_t                expected_results [$];

    int                     n_queued     = 0;
    int                     n_accepted   = 0;
    int                     n_checked    = 0;
    int                     n_errors     = 0;
    int                     n_resets     = 0;
    int                     n_ticks      = 0;
    int                     n_consulted  = 0;
    int                     n_good       = 0;
    int                     n_disables   = 0;
    int                     n_settings   = 1;
    bit                     quiet        = 1'b0;   // no idling on either side

    // Works out what the block reports for one request and advances the
    // predicted state.
    function automatic result_t qualify_request(item_t req);
        result_t     res;
        logic [31:0] since_tick;
        logic        tick;
        logic        recovering;
        int unsigned total;
        int unsigned filled;
        res = '0;
        if (req.action == ACT_RESET)
        begin
            // flags and ring fill only; time, warm-up, average and temperature stay
            fail_run  = '0;
            sens_on   = 1'b1;
            hist_full = 1'b0;
            hist_pos  = 0;
            n_resets++;
        end
        else
        begin
            since_tick = req.now_ms - last_tick;   // wraps at 2^32
            tick       = since_tick >= cfg_recovery;
            recovering = tick && !sens_on;
            if (tick)
            begin
                last_tick = req.now_ms;
                n_ticks++;
            end
            if (sens_on || recovering)
            begin
                res.reading_used = 1'b1;
                n_consulted++;
                if (req.gas_reading < cfg_min || req.gas_reading > cfg_max)
                begin
                    // a failure seen on a recovery tick while disabled leaves the count alone
                    if (sens_on)
                    begin
                        if (fail_run != FAIL_SAT)
                            fail_run++;
                        if (fail_run >= cfg_limit)
                        begin
                            sens_on = 1'b0;
                            n_disables++;
                        end
                    end
                end
                else
                begin
                    n_good++;
                    sens_on  = 1'b1;
                    fail_run = '0;
                    if (!warm_done && req.now_ms > cfg_warmup)
                        warm_done = 1'b1;
                    good_temp          = req.sensor_temperature;
                    hist_ppm[hist_pos] = req.gas_reading;
                    hist_pos           = (hist_pos + 1) % RING_LEN;
                    if (hist_pos == 0)
                        hist_full = 1'b1;
                    filled = hist_full ? RING_LEN : hist_pos;
                    total  = 0;
                    for (int i = 0; i < filled; i++)
                        total += hist_ppm[i];
                    avg_ppm = 16'(total / filled);
                end
            end
        end
        res.average_ppm     = avg_ppm;
        res.temperature_out = good_temp;
        res.sensor_enabled  = sens_on;
        res.warmed_up       = warm_done;
        res.failure_count   = fail_run;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: holds a request until taken, idles in random bursts
    // ------------------------------------------------------------------
    int                     send_gap     = 0;
    int                     send_odds    = 10;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                expected_results.push_back(qualify_request(req_bus));
                n_accepted++;
                // change idling habit now and then, including stretches without any
                if (n_accepted % 50 == 0)
                    send_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            end
            if (!item_valid || !item_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 99) < send_odds)
                    begin
                        send_gap = $urandom_range(1, 15) - 1;
                        item_valid <= 1'b0;
                    end
                    else
                    begin
                        req_bus    <= pending_requests.pop_front();
                        item_valid <= 1'b1;
                    end
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and stall generator
    // ------------------------------------------------------------------
    int                     stall_left   = 0;
    int                     take_odds    = 10;
    bit                     hold_done    = 1'b0;

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding: %p", $time, res_bus);
                    n_errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_bus.average_ppm !== want.average_ppm)
                    begin
                        $display("%0t: average_ppm expected %0d got %0d",
                                 $time, want.average_ppm, res_bus.average_ppm);
                        n_errors++;
                    end
                    if (res_bus.temperature_out !== want.temperature_out)
                    begin
                        $display("%0t: temperature_out expected %0d got %0d",
                                 $time, want.temperature_out, res_bus.temperature_out);
                        n_errors++;
                    end
                    if (res_bus.sensor_enabled !== want.sensor_enabled)
                    begin
                        $display("%0t: sensor_enabled expected %0b got %0b",
                                 $time, want.sensor_enabled, res_bus.sensor_enabled);
                        n_errors++;
                    end
                    if (res_bus.warmed_up !== want.warmed_up)
                    begin
                        $display("%0t: warmed_up expected %0b got %0b",
                                 $time, want.warmed_up, res_bus.warmed_up);
                        n_errors++;
                    end
                    if (res_bus.failure_count !== want.failure_count)
                    begin
                        $display("%0t: failure_count expected %0d got %0d",
                                 $time, want.failure_count, res_bus.failure_count);
                        n_errors++;
                    end
                    if (res_bus.reading_used !== want.reading_used)
                    begin
                        $display("%0t: reading_used expected %0b got %0b",
                                 $time, want.reading_used, res_bus.reading_used);
                        n_errors++;
                    end
                end
                n_checked++;
                if (n_checked % 40 == 0)
                    take_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            end
            // one long hold-off mid-run: the sender keeps offering, so the
            // internal queue fills and the block has to stall its input
            if (!hold_done && n_checked >= HOLD_AT)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < take_odds)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [31:0]            gen_now      = '0;
    int                     gen_burst    = 0;   // failures still to send in a burst

    task automatic push_req(logic action, logic [31:0] now, logic [15:0] ppm,
                            logic signed [7:0] temp);
        item_t req;
        req.action             = action;
        req.now_ms             = now;
        req.gas_reading        = ppm;
        req.sensor_temperature = temp;
        pending_requests.push_back(req);
        n_queued++;
    endtask

    // Register write: setup cycle, then access until pready.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_PPM:    cfg_min      = value[15:0];
            REG_MAX_PPM:    cfg_max      = value[15:0];
            REG_FAIL_LIMIT: cfg_limit    = value[3:0];
            REG_RECOVERY:   cfg_recovery = value;
            REG_WARMUP:     cfg_warmup   = value;
            default: ;
        endcase
    endtask

    // Waits until every queued request has produced its result, plus the
    // block's worst latency so nothing is still in flight.
    task automatic wait_drained();
        while (n_checked < n_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register setting followed by a burst of random requests. Most are
    // plausible sensor traffic (time creeping forward, mainly in-window
    // readings, failure bursts long enough to disable, leaps to the next
    // recovery tick); the rest is reset requests and junk.
    task automatic run_phase(logic [15:0] lo, logic [15:0] hi, logic [3:0] limit,
                             logic [31:0] recovery, logic [31:0] warmup, int count);
        int          roll;
        bit          bad;
        logic [15:0] ppm;
        int unsigned step_max;
        write_reg(REG_MIN_PPM, 32'(lo));
        write_reg(REG_MAX_PPM, 32'(hi));
        write_reg(REG_FAIL_LIMIT, 32'(limit));
        write_reg(REG_RECOVERY, recovery);
        write_reg(REG_WARMUP, warmup);
        n_settings++;
        step_max = (cfg_recovery >> 3) + 1;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                gen_now = $urandom;
            else if (roll < 14)
                gen_now = gen_now + cfg_recovery + $urandom_range(0, 3);
            else
                gen_now = gen_now + $urandom_range(0, step_max);
            if (gen_burst == 0 && $urandom_range(0, 9) == 0)
                gen_burst = cfg_limit + $urandom_range(0, 3);
            bad = (gen_burst > 0) || ($urandom_range(0, 9) == 0);
            if (gen_burst > 0)
                gen_burst--;
            if (roll < 7)
                ppm = 16'($urandom);
            else if (!bad && cfg_min <= cfg_max)
                ppm = 16'($urandom_range(cfg_max, cfg_min));
            else if (cfg_min > 0 && (cfg_max == 16'hFFFF || $urandom_range(0, 1) == 0))
                ppm = 16'($urandom_range(cfg_min - 1, 0));
            else if (cfg_max != 16'hFFFF)
                ppm = 16'($urandom_range(16'hFFFF, cfg_max + 1));
            else
                ppm = 16'($urandom);
            push_req((roll >= 96) ? ACT_RESET : ACT_UPDATE, gen_now, ppm, 8'($urandom));
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, register defaults (300..5000 ppm, limit 5,
        // 600 s recovery, 180 s warm-up).
        push_req(ACT_UPDATE, 32'd0,    16'd300,   -8'sd128);  // bottom of window
        push_req(ACT_UPDATE, 32'd1000, 16'd5000,  8'sd127);   // top of window
        push_req(ACT_UPDATE, 32'd2000, 16'd299,   8'sd0);     // just below
        push_req(ACT_UPDATE, 32'd3000, 16'd5001,  8'sd5);     // just above
        push_req(ACT_UPDATE, 32'd4000, 16'd0,     8'sd1);
        push_req(ACT_UPDATE, 32'd5000, 16'hFFFF,  -8'sd1);
        push_req(ACT_UPDATE, 32'd6000, 16'd12345, 8'sd7);     // fifth failure disables
        push_req(ACT_UPDATE, 32'd7000, 16'd1000,  8'sd3);     // disabled, no tick: ignored
        push_req(ACT_UPDATE, 32'd600000, 16'd20,  8'sd3);     // tick, failure while disabled
        push_req(ACT_UPDATE, 32'd600500, 16'd1000, 8'sd9);    // between ticks: ignored
        push_req(ACT_UPDATE, 32'd1200000, 16'd1000, 8'sd9);   // tick, good: re-enable, warm
        push_req(ACT_RESET, 32'hFFFF_FFFF, 16'hFFFF, -8'sd128);
        // refill past the ring length so it wraps
        for (int k = 0; k < 12; k++)
            push_req(ACT_UPDATE, 32'd1300000 + k * 250,
                     (k == 0) ? 16'd300 : (k == 1) ? 16'd5000 : 16'(300 + k * 391),
                     8'(k * 11 - 60));
        push_req(ACT_UPDATE, 32'hFFFF_FFFF, 16'd2500, 8'sd42); // time at its top
        push_req(ACT_UPDATE, 32'd5, 16'd2600, -8'sd3);         // wrapped difference, no tick
        gen_now = 32'd5;
        wait_drained();

        // Random part over a range of settings.
        // open window, every request a tick, immediate warm-up
        run_phase(16'd0, 16'hFFFF, 4'd15, 32'd0, 32'd0, PHASE_ITEMS);
        // inverted window, zero fail limit, longest intervals
        run_phase(16'hFFFF, 16'd0, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PHASE_ITEMS);
        run_phase(16'd1000, 16'd3000, 4'd3, 32'd5000, 32'd100000, PHASE_ITEMS);
        // one-value window, limit 1, shortest non-zero interval
        run_phase(16'd2000, 16'd2000, 4'd1, 32'd1, $urandom, PHASE_ITEMS);
        run_phase(MIN_PPM_RST, MAX_PPM_RST, FAIL_LIMIT_RST, RECOVERY_RST, WARMUP_RST,
                  PHASE_ITEMS);
        // last stretch back to back on both sides
        quiet = 1'b1;
        begin
            logic [15:0] a;
            logic [15:0] b;
            a = 16'($urandom);
            b = 16'($urandom);
            run_phase((a < b) ? a : b, (a < b) ? b : a, 4'($urandom_range(1, 15)),
                      $urandom_range(0, 20000), $urandom, PHASE_ITEMS);
        end

        $display("covered %0d requests (%0d resets) over %0d register settings",
                 n_accepted, n_resets, n_settings);
        $display("%0d readings consulted, %0d good, %0d recovery ticks, %0d disables;",
                 n_consulted, n_good, n_ticks, n_disables);
        $display("%0d bad fields", n_errors);
        if (n_errors == 0)
            $display("gas_sensor_qualifier_averager regression: pass");
        else
            $display("gas_sensor_qualifier_averager regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d of %0d results checked", n_checked, n_queued);
        $display("gas_sensor_qualifier_averager regression: fail");
        $finish;
    end

endmodule
